[hdl/tdds_pkg.sv]
// Shared types, constants and codes for the toroidal diffusion and degradation step block.
`timescale 1ns / 1ps
`default_nettype none

package tdds_pkg;

  // Default grid geometry, handed to the top level as parameter defaults.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int SPECIES_DEF    = 16;

  // Field and register widths.
  localparam int COORD_W    = 6;
  localparam int SPEC_W     = 4;
  localparam int AMOUNT_W   = 32;
  localparam int OUTFLOW_W  = 48;
  localparam int RATE_W     = 16;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Reset value of both wrap sizes.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Datapath widths: nine-value sum, stencil magnitude and its split for the multiplier.
  localparam int SUM_W    = AMOUNT_W + 4;
  localparam int MAG_W    = 35;
  localparam int MUL_LO_W = 18;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_SWAP  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  // Neighbor offsets along one axis.
  localparam logic [1:0] NB_PREV = 2'd0;
  localparam logic [1:0] NB_SAME = 2'd1;
  localparam logic [1:0] NB_NEXT = 2'd2;

  // Input request.
  typedef struct packed {
    logic [1:0]          operation;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [SPEC_W-1:0]   species_index;
    logic [AMOUNT_W-1:0] amount_in;
  } in_item_t;

  // Result request.
  typedef struct packed {
    logic [AMOUNT_W-1:0]  amount_out;
    logic [OUTFLOW_W-1:0] outflow_total;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear;
    logic       latch;
    logic       wr_item;
    logic       swap;
    logic       zero_res;
    logic       rd_take;
    logic       mod_init;
    logic       mod_step;
    logic       nb_rd;
    logic [1:0] nb_col;
    logic [1:0] nb_row;
    logic       diff;
    logic       mul_lo;
    logic       mul_hi;
    logic       fresh;
    logic       degr;
    logic       wb;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clear_last;
    logic [1:0] op;
  } sts_t;

endpackage

`default_nettype wire

[hdl/tdds_ctrl.sv]
// Controller state machine that sequences clearing, requests and the stencil step.
`timescale 1ns / 1ps
`default_nettype none

module tdds_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire tdds_pkg::sts_t sts,
  output tdds_pkg::cmd_t      cmd
);
  import tdds_pkg::*;

  localparam int CW = $clog2(COORD_W);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_DISPATCH = 14'b00000000000100,
    S_RDWAIT   = 14'b00000000001000,
    S_MOD      = 14'b00000000010000,
    S_NBRD     = 14'b00000000100000,
    S_SUMEND   = 14'b00000001000000,
    S_DIFF     = 14'b00000010000000,
    S_MULLO    = 14'b00000100000000,
    S_MULHI    = 14'b00001000000000,
    S_FRESH    = 14'b00010000000000,
    S_DEGR     = 14'b00100000000000,
    S_WB       = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      col_r, col_nxt;
  logic [1:0]      row_r, row_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_WRITE: begin
            cmd.wr_item  = 1'b1;
            cmd.zero_res = 1'b1;
            state_nxt    = S_FIN;
          end
          OP_SWAP: begin
            cmd.swap     = 1'b1;
            cmd.zero_res = 1'b1;
            state_nxt    = S_FIN;
          end
          OP_READ: begin
            state_nxt = S_RDWAIT;
          end
          default: begin
            cmd.mod_init = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_MOD;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_FIN;
      end
      // One remainder bit per cycle for both coordinates.
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt_r == CW'(COORD_W - 1)) begin
          cnt_nxt   = '0;
          col_nxt   = NB_PREV;
          row_nxt   = NB_PREV;
          state_nxt = S_NBRD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      // Walk the 3x3 neighborhood, one read per cycle.
      S_NBRD: begin
        cmd.nb_rd  = 1'b1;
        cmd.nb_col = col_r;
        cmd.nb_row = row_r;
        if (col_r == NB_NEXT) begin
          col_nxt = NB_PREV;
          if (row_r == NB_NEXT) begin
            state_nxt = S_SUMEND;
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end else begin
          col_nxt = col_r + 2'd1;
        end
      end
      S_SUMEND: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MULLO;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FRESH;
      end
      S_FRESH: begin
        cmd.fresh = 1'b1;
        state_nxt = S_DEGR;
      end
      S_DEGR: begin
        cmd.degr  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_FIN;
      end
      // Hand the result over once the output register is free.
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      col_r       <= NB_PREV;
      row_r       <= NB_PREV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/tdds_dp.sv]
// Datapath with the banked concentration store, wrap arithmetic, stencil sum and decay.
`timescale 1ns / 1ps
`default_nettype none

module tdds_dp #(
  parameter int MAX_WIDTH  = tdds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tdds_pkg::MAX_HEIGHT_DEF,
  parameter int SPECIES    = tdds_pkg::SPECIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tdds_pkg::in_item_t                in_data,
  input  wire logic                              cfg_we,
  input  wire logic [tdds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tdds_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire tdds_pkg::cmd_t                    cmd,
  output tdds_pkg::sts_t                         sts,
  output tdds_pkg::out_item_t                    out_data
);
  import tdds_pkg::*;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int SW      = (SPECIES > 1) ? $clog2(SPECIES) : 1;
  localparam int AW      = 1 + YW + XW + SW;
  localparam int DEPTH   = 2 ** AW;
  localparam int COORD_N = 2 ** COORD_W;
  localparam int SPEC_N  = 2 ** SPEC_W;
  localparam int PROD_W  = RATE_W + MAG_W;
  localparam int DMAG_W  = PROD_W - 16;
  localparam int FR_W    = DMAG_W + 1;
  localparam int MULP_W  = RATE_W + MUL_LO_W;
  localparam int DP_W    = AMOUNT_W + RATE_W;

  // Configuration registers.
  logic [RATE_W-1:0] spread_frac_r, decay_frac_r;
  logic [SIZE_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_frac_r <= '0;
      decay_frac_r  <= '0;
      width_r       <= SIZE_RESET;
      height_r      <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPREAD: spread_frac_r <= cfg_data[RATE_W-1:0];
        CFG_DECAY:  decay_frac_r  <= cfg_data[RATE_W-1:0];
        CFG_WIDTH:  width_r       <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: height_r      <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective wrap sizes: zero acts as one, oversize acts as the grid maximum.
  logic [SIZE_W-1:0] w_eff, h_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Request register.
  in_item_t item_r;
  logic     bank_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  assign sts.op = item_r.operation;

  // Constant tables that fold write and read addresses into the grid.
  logic [XW-1:0] xmod_tbl [COORD_N];
  logic [YW-1:0] ymod_tbl [COORD_N];
  logic [SW-1:0] smod_tbl [SPEC_N];

  for (genvar g = 0; g < COORD_N; g++) begin : g_coord_tbl
    assign xmod_tbl[g] = XW'(g % MAX_WIDTH);
    assign ymod_tbl[g] = YW'(g % MAX_HEIGHT);
  end

  for (genvar g = 0; g < SPEC_N; g++) begin : g_spec_tbl
    assign smod_tbl[g] = SW'(g % SPECIES);
  end

  logic [SW-1:0] item_s;
  logic [AW-1:0] item_addr;

  assign item_s    = smod_tbl[item_r.species_index];
  assign item_addr = {bank_r, ymod_tbl[item_r.cell_y], xmod_tbl[item_r.cell_x], item_s};

  // Restoring remainder units for the step coordinates, one bit per cycle.
  function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] rem,
                                                 input logic              b,
                                                 input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SIZE_W-1:0];
  endfunction

  logic [COORD_W-1:0] xsh_r, ysh_r;
  logic [SIZE_W-1:0]  xrem_r, yrem_r;

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      xsh_r  <= item_r.cell_x;
      ysh_r  <= item_r.cell_y;
      xrem_r <= '0;
      yrem_r <= '0;
    end else if (cmd.mod_step) begin
      xrem_r <= rem_step(xrem_r, xsh_r[COORD_W-1], w_eff);
      yrem_r <= rem_step(yrem_r, ysh_r[COORD_W-1], h_eff);
      xsh_r  <= xsh_r << 1;
      ysh_r  <= ysh_r << 1;
    end
  end

  // Toroidal neighbor coordinates.
  logic [SIZE_W-1:0] nx, ny;

  always_comb begin
    case (cmd.nb_col)
      NB_PREV: nx = (xrem_r == '0) ? w_eff - SIZE_W'(1) : xrem_r - SIZE_W'(1);
      NB_NEXT: nx = (xrem_r + SIZE_W'(1) == w_eff) ? '0 : xrem_r + SIZE_W'(1);
      default: nx = xrem_r;
    endcase
    case (cmd.nb_row)
      NB_PREV: ny = (yrem_r == '0) ? h_eff - SIZE_W'(1) : yrem_r - SIZE_W'(1);
      NB_NEXT: ny = (yrem_r + SIZE_W'(1) == h_eff) ? '0 : yrem_r + SIZE_W'(1);
      default: ny = yrem_r;
    endcase
  end

  // Bank select and clearing sweep.
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.swap) begin
        bank_r <= ~bank_r;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  assign sts.clear_last = &clr_cnt_r;

  // Concentration store: one write and one registered read per cycle.
  logic [AMOUNT_W-1:0] mem [DEPTH];
  logic [AMOUNT_W-1:0] rd_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [AMOUNT_W-1:0] mem_wd;
  logic [AMOUNT_W-1:0] new_amt;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.wr_item) begin
      mem_we = 1'b1;
      mem_wa = item_addr;
      mem_wd = item_r.amount_in;
    end else if (cmd.wb) begin
      mem_we = 1'b1;
      mem_wa = {~bank_r, YW'(yrem_r), XW'(xrem_r), item_s};
      mem_wd = new_amt;
    end
  end

  assign mem_ra = cmd.nb_rd ? {bank_r, YW'(ny), XW'(nx), item_s} : item_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  // Neighborhood sum, with the center value kept as the cell's own amount.
  logic                pend_r, ctr_pend_r;
  logic [SUM_W-1:0]    sum_r;
  logic [AMOUNT_W-1:0] self_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      ctr_pend_r <= 1'b0;
    end else begin
      pend_r     <= cmd.nb_rd;
      ctr_pend_r <= cmd.nb_rd && (cmd.nb_col == NB_SAME) && (cmd.nb_row == NB_SAME);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      sum_r <= '0;
    end else if (pend_r) begin
      sum_r <= sum_r + SUM_W'(rd_r);
    end
    if (ctr_pend_r) begin
      self_r <= rd_r;
    end
  end

  // Stencil difference as sign and magnitude.
  logic [SUM_W-1:0] nine_self, s_mag;
  logic             s_neg;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;

  assign nine_self = SUM_W'({self_r, 3'b000}) + SUM_W'(self_r);
  assign s_neg     = nine_self > sum_r;
  assign s_mag     = s_neg ? nine_self - sum_r : sum_r - nine_self;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      mag_r <= s_mag[MAG_W-1:0];
      neg_r <= s_neg;
    end
  end

  // Rate times magnitude in two partial products on one multiplier.
  logic [MUL_LO_W-1:0] mul_b;
  logic [MULP_W-1:0]   mul_p;
  logic [PROD_W-1:0]   prod_r;

  assign mul_b = cmd.mul_hi ? MUL_LO_W'(mag_r[MAG_W-1:MUL_LO_W]) : mag_r[MUL_LO_W-1:0];
  assign mul_p = MULP_W'(spread_frac_r) * MULP_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod_r <= PROD_W'(mul_p);
    end else if (cmd.mul_hi) begin
      prod_r <= prod_r + {mul_p[PROD_W-MUL_LO_W-1:0], MUL_LO_W'(0)};
    end
  end

  // Round to Q16.16 with ties upward, apply to the cell and clamp.
  logic [PROD_W-1:0]   rnd;
  logic [DMAG_W-1:0]   dmag;
  logic [FR_W-1:0]     pos_sum;
  logic [AMOUNT_W-1:0] fresh, fresh_r;

  assign rnd     = prod_r + (neg_r ? PROD_W'(32767) : PROD_W'(32768));
  assign dmag    = rnd[PROD_W-1:16];
  assign pos_sum = FR_W'(self_r) + FR_W'(dmag);

  always_comb begin
    if (!neg_r) begin
      fresh = (pos_sum > FR_W'({AMOUNT_W{1'b1}})) ? '1 : pos_sum[AMOUNT_W-1:0];
    end else begin
      fresh = (FR_W'(dmag) > FR_W'(self_r)) ? '0 : self_r - dmag[AMOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fresh) begin
      fresh_r <= fresh;
    end
  end

  // Degraded share, rounded to Q16.16.
  logic [DP_W-1:0]     dprod;
  logic [AMOUNT_W-1:0] degr_r;

  assign dprod = DP_W'(fresh_r) * DP_W'(decay_frac_r) + DP_W'(32768);

  always_ff @(posedge clk) begin
    if (cmd.degr) begin
      degr_r <= dprod[DP_W-1:16];
    end
  end

  // Write-back amount and saturating outflow.
  logic [OUTFLOW_W-1:0] acc_r;
  logic [OUTFLOW_W:0]   acc_sum;

  assign new_amt = fresh_r - degr_r;
  assign acc_sum = {1'b0, acc_r} + (OUTFLOW_W + 1)'(degr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.wb) begin
      acc_r <= acc_sum[OUTFLOW_W] ? '1 : acc_sum[OUTFLOW_W-1:0];
    end
  end

  // Result and output registers.
  logic [AMOUNT_W-1:0] result_r;
  out_item_t           out_r;

  always_ff @(posedge clk) begin
    if (cmd.zero_res) begin
      result_r <= '0;
    end else if (cmd.rd_take) begin
      result_r <= rd_r;
    end else if (cmd.wb) begin
      result_r <= new_amt;
    end
    if (cmd.out_load) begin
      out_r.amount_out    <= result_r;
      out_r.outflow_total <= acc_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[hdl/toroidal_diffusion_degradation_step_top.sv]
// Top level of the toroidal diffusion and degradation step block.
//
//   Channel | Ports                           | Moves
//   --------+---------------------------------+-------------------------------------
//   input   | in_valid, in_ready, in_data     | operation request (write/step/swap/read)
//   result  | out_valid, out_ready, out_data  | amount and outflow total, one per request
//   config  | cfg_we, cfg_index, cfg_data     | register writes, no read-back
//
// A step request runs the bit-serial wrap remainder, then nine reads from the store, then
// the arithmetic steps: difference, low and high partial products, fresh amount, decay
// and write-back.
// After reset the store is swept to zero, one entry a cycle, over all 2^(1+YW+XW+SW) entries
// (131072 with the default geometry); no request is accepted during the sweep.
// A new request is accepted while a finished result still waits in the output register;
// a stalled output holds only the final hand-over.
`timescale 1ns / 1ps
`default_nettype none

module toroidal_diffusion_degradation_step_top #(
  parameter int MAX_WIDTH  = tdds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tdds_pkg::MAX_HEIGHT_DEF,
  parameter int SPECIES    = tdds_pkg::SPECIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tdds_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tdds_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tdds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tdds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tdds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tdds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store and arithmetic.
  tdds_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SPECIES    (SPECIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
